### rtl/core/sbwq_pkg.sv
// Package for the semaphore bank with wait queues.
// Holds bank sizes, field widths, operation and status codes, shared types and ring helpers.
// Used by every file of the block; depends on nothing.
package sbwq_pkg;

   localparam int NUM_SEMS  = 16;
   localparam int RING_SIZE = 16;

   localparam int SEM_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int PTR_W   = $clog2(RING_SIZE);
   localparam int WADDR_W = ((NUM_SEMS * RING_SIZE) > 1) ? $clog2(NUM_SEMS * RING_SIZE) : 1;

   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int REQ_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 3;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INIT = 2'd0,
      OP_UP   = 2'd1,
      OP_DOWN = 2'd2,
      OP_BAD  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_SUSP = 2'd1,
      ST_ERR  = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PTR_W-1:0]   head;
      logic [PTR_W-1:0]   tail;
   } sem_state_type;

   typedef struct packed {
      sem_state_type      next_state;
      logic               state_we;
      logic               wait_we;
      logic [PTR_W-1:0]   wait_ptr;
      status_type         status;
      logic               wake;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } upd_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RING_SIZE - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] h,
                                                   input logic [PTR_W-1:0] t);
      logic [PTR_W:0] d;
      if (t >= h) begin
         d = {1'b0, t} - {1'b0, h};
      end else begin
         d = {1'b0, t} + (PTR_W+1)'(RING_SIZE) - {1'b0, h};
      end
      return d[PTR_W-1:0];
   endfunction

endpackage

### rtl/core/sbwq_update.sv
// Next-state and result logic for one semaphore operation.
// Takes the semaphore entry read from the state memory and the latched transaction.
// Depends on sbwq_pkg.
module sbwq_update (
   input  sbwq_pkg::opcode_type                op,
   input  logic                                bad_index,
   input  logic [sbwq_pkg::VALUE_W-1:0]        init_value,
   input  sbwq_pkg::sem_state_type             cur,
   output sbwq_pkg::upd_type                   upd
);

   logic [sbwq_pkg::PTR_W-1:0] cur_cnt;
   logic [sbwq_pkg::PTR_W-1:0] new_cnt;
   sbwq_pkg::sem_state_type    nxt;

   assign cur_cnt = sbwq_pkg::ring_count(cur.head, cur.tail);

   always_comb begin
      nxt              = cur;
      upd.state_we     = 1'b0;
      upd.wait_we      = 1'b0;
      upd.wait_ptr     = cur.tail;
      upd.status       = sbwq_pkg::ST_OK;
      upd.wake         = 1'b0;
      case (op)
         sbwq_pkg::OP_INIT: begin
            nxt.value    = init_value;
            nxt.head     = '0;
            nxt.tail     = '0;
            upd.state_we = 1'b1;
         end
         sbwq_pkg::OP_UP: begin
            upd.state_we = 1'b1;
            if (cur_cnt != '0) begin
               upd.wake = 1'b1;
               nxt.head = sbwq_pkg::ptr_inc(cur.head);
            end else if (cur.value != sbwq_pkg::VALUE_MAX) begin
               nxt.value = cur.value + sbwq_pkg::VALUE_W'(1);
            end
         end
         sbwq_pkg::OP_DOWN: begin
            if (cur.value != '0) begin
               nxt.value    = cur.value - sbwq_pkg::VALUE_W'(1);
               upd.state_we = 1'b1;
            end else if (cur_cnt == sbwq_pkg::PTR_W'(sbwq_pkg::RING_SIZE - 1)) begin
               upd.status = sbwq_pkg::ST_ERR;
            end else begin
               nxt.tail     = sbwq_pkg::ptr_inc(cur.tail);
               upd.state_we = 1'b1;
               upd.wait_we  = 1'b1;
               upd.status   = sbwq_pkg::ST_SUSP;
            end
         end
         default: begin
            upd.status = sbwq_pkg::ST_ERR;
         end
      endcase
      if (bad_index) begin
         nxt          = cur;
         upd.state_we = 1'b0;
         upd.wait_we  = 1'b0;
         upd.status   = sbwq_pkg::ST_ERR;
         upd.wake     = 1'b0;
      end
      new_cnt        = sbwq_pkg::ring_count(nxt.head, nxt.tail);
      upd.next_state = nxt;
      upd.value      = bad_index ? '0 : nxt.value;
      upd.count      = bad_index ? '0 : sbwq_pkg::COUNT_W'(new_cnt);
   end

endmodule

### rtl/core/semaphore_bank_with_wait_queues_unit.sv
// Top level of the semaphore bank with per-semaphore FIFO wait queues.
// Holds the state memory, the waiter memory, the sequencer and the result register.
// Depends on sbwq_pkg and sbwq_update.
//
//   Channel  Direction  Payload
//   req_*    in         tuser: opcode; tdata: sem_index, init_value, requester
//   rsp_*    out        tuser: status, wake_valid; tdata: wake_id, sem_value, waiter_count
//
// Each transaction reads the state memory when accepted, then does the update and
// the waiter memory access in S_EXEC; requests are taken in S_IDLE, or in S_WAKE once out_free.
// The result register lets the next request enter while a result waits on rsp_tready.
// Reset is synchronous; per-entry valid bits make every semaphore read as zero after it.
// A stalled result holds the sequencer in its final cycle until rsp_tready is seen.
module semaphore_bank_with_wait_queues_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: sem_index[7:0], init_value[23:8], requester[33:24], zero fill.
   input  logic [sbwq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: opcode[1:0].
   input  logic [sbwq_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: wake_id[9:0], sem_value[25:10], waiter_count[29:26], zero fill.
   output logic [sbwq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0], wake_valid[2].
   output logic [sbwq_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_WAKE = 3'b100
   } fsm_type;

   fsm_type fsm_ff, fsm_in;

   logic [sbwq_pkg::INDEX_W-1:0] req_index;
   logic [sbwq_pkg::SEM_W-1:0]   req_addr;
   logic                         accept;
   logic                         out_free;

   sbwq_pkg::opcode_type             op_ff;
   logic                             bad_ff;
   logic [sbwq_pkg::SEM_W-1:0]       addr_ff;
   logic [sbwq_pkg::VALUE_W-1:0]     init_ff;
   logic [sbwq_pkg::REQ_W-1:0]       requester_ff;

   sbwq_pkg::sem_state_type          state_mem [sbwq_pkg::NUM_SEMS];
   logic [sbwq_pkg::NUM_SEMS-1:0]    valid_ff;
   sbwq_pkg::sem_state_type          state_rd_ff;
   logic                             valid_rd_ff;
   sbwq_pkg::sem_state_type          cur_state;

   logic [sbwq_pkg::REQ_W-1:0]       wait_mem [sbwq_pkg::NUM_SEMS * sbwq_pkg::RING_SIZE];
   logic [sbwq_pkg::REQ_W-1:0]       wait_rd_ff;
   logic [sbwq_pkg::WADDR_W-1:0]     wait_base;
   logic [sbwq_pkg::WADDR_W-1:0]     wait_wr_addr;
   logic [sbwq_pkg::WADDR_W-1:0]     wait_rd_addr;

   sbwq_pkg::upd_type                upd;

   sbwq_pkg::status_type             status_ff;
   logic                             wake_ff;
   logic [sbwq_pkg::VALUE_W-1:0]     value_ff;
   logic [sbwq_pkg::COUNT_W-1:0]     count_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sbwq_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [sbwq_pkg::RSP_USER_W-1:0]  rsp_user_ff;
   logic [sbwq_pkg::REQ_W-1:0]       wake_id;

   assign req_index  = req_tdata[sbwq_pkg::INDEX_W-1:0];
   assign req_addr   = req_index[sbwq_pkg::SEM_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (fsm_ff == S_IDLE) || ((fsm_ff == S_WAKE) && out_free);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         S_IDLE: begin
            if (accept) begin
               fsm_in = S_EXEC;
            end
         end
         S_EXEC: begin
            fsm_in = S_WAKE;
         end
         S_WAKE: begin
            if (out_free) begin
               fsm_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= sbwq_pkg::opcode_type'(req_tuser);
         bad_ff       <= {1'b0, req_index} >= (sbwq_pkg::INDEX_W+1)'(sbwq_pkg::NUM_SEMS);
         addr_ff      <= req_addr;
         init_ff      <= req_tdata[sbwq_pkg::INDEX_W +: sbwq_pkg::VALUE_W];
         requester_ff <= req_tdata[sbwq_pkg::INDEX_W+sbwq_pkg::VALUE_W +: sbwq_pkg::REQ_W];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         state_rd_ff <= state_mem[req_addr];
      end
      if ((fsm_ff == S_EXEC) && upd.state_we) begin
         state_mem[addr_ff] <= upd.next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         if (accept) begin
            valid_rd_ff <= valid_ff[req_addr];
         end
         if ((fsm_ff == S_EXEC) && upd.state_we) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   assign cur_state = valid_rd_ff ? state_rd_ff : '0;

   sbwq_update u_update (
      .op         (op_ff),
      .bad_index  (bad_ff),
      .init_value (init_ff),
      .cur        (cur_state),
      .upd        (upd)
   );

   assign wait_base    = sbwq_pkg::WADDR_W'(addr_ff) * sbwq_pkg::WADDR_W'(sbwq_pkg::RING_SIZE);
   assign wait_wr_addr = wait_base + sbwq_pkg::WADDR_W'(upd.wait_ptr);
   assign wait_rd_addr = wait_base + sbwq_pkg::WADDR_W'(cur_state.head);

   always_ff @(posedge clock) begin
      if (fsm_ff == S_EXEC) begin
         wait_rd_ff <= wait_mem[wait_rd_addr];
         if (upd.wait_we) begin
            wait_mem[wait_wr_addr] <= requester_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fsm_ff == S_EXEC) begin
         status_ff <= upd.status;
         wake_ff   <= upd.wake;
         value_ff  <= upd.value;
         count_ff  <= upd.count;
      end
   end

   assign wake_id = wake_ff ? wait_rd_ff : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((fsm_ff == S_WAKE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((fsm_ff == S_WAKE) && out_free) begin
         rsp_data_ff <= sbwq_pkg::RSP_DATA_W'({count_ff, value_ff, wake_id});
         rsp_user_ff <= {wake_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/core/sbwq_checker.sv
// Port-level checker for the semaphore bank, bound to the top level.
// Watches the request and result handshakes and the result encoding.
// Depends on sbwq_pkg and semaphore_bank_with_wait_queues_unit.
module sbwq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sbwq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [sbwq_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   // A stalled result must keep its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // After an accept the sequencer is in S_EXEC with req_tready low, so it cannot take two in a row.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in consecutive cycles");

   // A released waiter only comes with an ok status.
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == sbwq_pkg::ST_OK)
      else $error("wake reported with non-ok status");

   // Without a wake the identity field is zero.
   a_wake_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata[sbwq_pkg::REQ_W-1:0] == '0)
      else $error("wake identity set without a wake");

   // The reserved status code is never produced.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != sbwq_pkg::ST_RSVD)
      else $error("reserved status code on result");

endmodule

bind semaphore_bank_with_wait_queues_unit sbwq_checker u_sbwq_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the semaphore bank with per-semaphore wait queues.
// Holds a behavioral model of the bank, a stream driver, a response monitor and a watchdog.
// Depends on sbwq_pkg and semaphore_bank_with_wait_queues_unit.
module tb_top;

   localparam int IDLE_LIMIT = 5000;
   localparam int TARGET_REQUESTS = 400;

   typedef struct {
      sbwq_pkg::opcode_type         op;
      logic [sbwq_pkg::INDEX_W-1:0] idx;
      logic [sbwq_pkg::VALUE_W-1:0] init;
      logic [sbwq_pkg::REQ_W-1:0]   who;
   } sem_request_type;

   typedef struct {
      sbwq_pkg::status_type         status;
      logic                         wake;
      logic [sbwq_pkg::REQ_W-1:0]   wake_id;
      logic [sbwq_pkg::VALUE_W-1:0] value;
      logic [sbwq_pkg::COUNT_W-1:0] count;
   } sem_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sbwq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [sbwq_pkg::OPCODE_W-1:0]   req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sbwq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [sbwq_pkg::RSP_USER_W-1:0] rsp_tuser;

   sem_request_type pending_requests[$];
   sem_result_type  expected_results[$];
   sem_request_type current_request;

   int bank_value[sbwq_pkg::NUM_SEMS];
   int bank_head[sbwq_pkg::NUM_SEMS];
   int bank_tail[sbwq_pkg::NUM_SEMS];
   int waiter_mem[sbwq_pkg::NUM_SEMS*sbwq_pkg::RING_SIZE];

   int total_requests = 1;
   int requests_accepted = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int wake_count = 0;
   int suspend_count = 0;
   int error_count = 0;
   int ring_full_count = 0;
   int saturate_count = 0;

   semaphore_bank_with_wait_queues_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int traffic_phase();
      return (requests_accepted * 3) / total_requests;
   endfunction

   function automatic int sender_idle_pct();
      int p;
      p = traffic_phase();
      return (p == 0) ? 36 : (p == 1) ? 49 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      int p;
      p = traffic_phase();
      return (p == 0) ? 49 : (p == 1) ? 36 : 0;
   endfunction

   function automatic int ring_waiters(input int s);
      return (bank_tail[s] + sbwq_pkg::RING_SIZE - bank_head[s]) % sbwq_pkg::RING_SIZE;
   endfunction

   task automatic predict_semaphore_op(input sem_request_type r);
      sem_result_type e;
      int             s;
      int             cnt;
      e.status  = sbwq_pkg::ST_ERR;
      e.wake    = 1'b0;
      e.wake_id = '0;
      e.value   = '0;
      e.count   = '0;
      if (r.idx < sbwq_pkg::NUM_SEMS) begin
         s = int'(r.idx);
         cnt = ring_waiters(s);
         e.status = sbwq_pkg::ST_OK;
         case (r.op)
            sbwq_pkg::OP_INIT: begin
               bank_value[s] = int'(r.init);
               bank_head[s] = 0;
               bank_tail[s] = 0;
            end
            sbwq_pkg::OP_UP: begin
               if (cnt > 0) begin
                  e.wake = 1'b1;
                  e.wake_id = sbwq_pkg::REQ_W'(
                     waiter_mem[s*sbwq_pkg::RING_SIZE + bank_head[s]]);
                  bank_head[s] = (bank_head[s] + 1) % sbwq_pkg::RING_SIZE;
                  wake_count++;
               end else if (bank_value[s] < sbwq_pkg::VALUE_MAX) begin
                  bank_value[s]++;
               end else begin
                  saturate_count++;
               end
            end
            sbwq_pkg::OP_DOWN: begin
               if (bank_value[s] > 0) begin
                  bank_value[s]--;
               end else if (cnt >= sbwq_pkg::RING_SIZE - 1) begin
                  e.status = sbwq_pkg::ST_ERR;
                  ring_full_count++;
               end else begin
                  waiter_mem[s*sbwq_pkg::RING_SIZE + bank_tail[s]] = int'(r.who);
                  bank_tail[s] = (bank_tail[s] + 1) % sbwq_pkg::RING_SIZE;
                  e.status = sbwq_pkg::ST_SUSP;
                  suspend_count++;
               end
            end
            default: begin
               e.status = sbwq_pkg::ST_ERR;
            end
         endcase
         e.value = sbwq_pkg::VALUE_W'(bank_value[s]);
         e.count = sbwq_pkg::COUNT_W'(ring_waiters(s));
      end
      if (e.status == sbwq_pkg::ST_ERR) error_count++;
      expected_results.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: result %0d: %s is 0x%0h, expected 0x%0h",
               $time, results_checked, what, got, want);
   endtask

   task automatic check_result();
      sem_result_type e;
      if (expected_results.size() == 0) begin
         report_mismatch("unrequested transaction, tdata", 32'(rsp_tdata), 32'd0);
      end else begin
         e = expected_results.pop_front();
         if (rsp_tuser[1:0] !== e.status)
            report_mismatch("status", 32'(rsp_tuser[1:0]), 32'(e.status));
         if (rsp_tuser[2] !== e.wake)
            report_mismatch("wake_valid", 32'(rsp_tuser[2]), 32'(e.wake));
         if (rsp_tdata[9:0] !== e.wake_id)
            report_mismatch("wake_id", 32'(rsp_tdata[9:0]), 32'(e.wake_id));
         if (rsp_tdata[25:10] !== e.value)
            report_mismatch("sem_value", 32'(rsp_tdata[25:10]), 32'(e.value));
         if (rsp_tdata[29:26] !== e.count)
            report_mismatch("waiter_count", 32'(rsp_tdata[29:26]), 32'(e.count));
      end
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_semaphore_op(current_request);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               current_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, current_request.who, current_request.init,
                             current_request.idx};
               req_tuser <= current_request.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic queue_request(input sbwq_pkg::opcode_type op, input int idx, input int init,
                                input int who);
      sem_request_type r;
      r.op = op;
      r.idx = sbwq_pkg::INDEX_W'(idx);
      r.init = sbwq_pkg::VALUE_W'(init);
      r.who = sbwq_pkg::REQ_W'(who);
      pending_requests.push_back(r);
   endtask

   function automatic int pick_init_value();
      int k;
      k = $urandom_range(0, 9);
      return (k == 0) ? 0 : (k == 1) ? 65535 : (k == 2) ? 65534 :
             (k == 3) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
   endfunction

   function automatic int pick_requester();
      return $urandom_range(0, 1023);
   endfunction

   initial begin
      int kind;
      int s;
      int n;
      int k;
      for (int i = 0; i < sbwq_pkg::NUM_SEMS; i++) begin
         bank_value[i] = 0;
         bank_head[i] = 0;
         bank_tail[i] = 0;
      end

      // Directed opening: value extremes, saturation, queue and wake, bad index and opcode.
      queue_request(sbwq_pkg::OP_UP, 3, 0, 0);
      queue_request(sbwq_pkg::OP_DOWN, 4, 0, 0);
      queue_request(sbwq_pkg::OP_INIT, 0, 65535, 0);
      queue_request(sbwq_pkg::OP_UP, 0, 0, 1023);
      queue_request(sbwq_pkg::OP_DOWN, 0, 0, 0);
      queue_request(sbwq_pkg::OP_INIT, 15, 0, 0);
      queue_request(sbwq_pkg::OP_UP, 15, 0, 0);
      queue_request(sbwq_pkg::OP_DOWN, 15, 0, 0);
      queue_request(sbwq_pkg::OP_DOWN, 15, 0, 1023);
      queue_request(sbwq_pkg::OP_DOWN, 15, 0, 0);
      queue_request(sbwq_pkg::OP_DOWN, 15, 0, 682);
      queue_request(sbwq_pkg::OP_UP, 15, 0, 0);
      queue_request(sbwq_pkg::OP_UP, 15, 0, 0);
      queue_request(sbwq_pkg::OP_INIT, 15, 21845, 341);
      queue_request(sbwq_pkg::OP_DOWN, 16, 0, 0);
      queue_request(sbwq_pkg::OP_UP, 255, 65535, 1023);
      queue_request(sbwq_pkg::OP_INIT, 128, 43690, 0);
      queue_request(sbwq_pkg::OP_BAD, 0, 0, 0);
      queue_request(sbwq_pkg::OP_BAD, 200, 65535, 1023);
      queue_request(sbwq_pkg::OP_INIT, 1, 1, 0);
      queue_request(sbwq_pkg::OP_DOWN, 1, 0, 0);
      queue_request(sbwq_pkg::OP_DOWN, 1, 0, 512);

      // Random part: ring floods and drains, mixed traffic, and noise.
      while (pending_requests.size() < TARGET_REQUESTS) begin
         kind = $urandom_range(0, 9);
         s = $urandom_range(0, sbwq_pkg::NUM_SEMS - 1);
         if (kind <= 2) begin
            queue_request(sbwq_pkg::OP_INIT, s, $urandom_range(0, 2), pick_requester());
            n = $urandom_range(3, sbwq_pkg::RING_SIZE + 2);
            for (int i = 0; i < n; i++) queue_request(sbwq_pkg::OP_DOWN, s, pick_init_value(),
                                                      pick_requester());
            k = $urandom_range(1, n + 2);
            for (int i = 0; i < k; i++) queue_request(sbwq_pkg::OP_UP, s, pick_init_value(),
                                                      pick_requester());
         end else if (kind <= 7) begin
            n = $urandom_range(4, 10);
            for (int i = 0; i < n; i++) begin
               k = $urandom_range(0, 19);
               if (k == 0)
                  queue_request(sbwq_pkg::OP_INIT, s, pick_init_value(), pick_requester());
               else if (k < 10)
                  queue_request(sbwq_pkg::OP_UP, s, pick_init_value(), pick_requester());
               else
                  queue_request(sbwq_pkg::OP_DOWN, s, pick_init_value(), pick_requester());
               if ($urandom_range(0, 3) == 0) s = $urandom_range(0, sbwq_pkg::NUM_SEMS - 1);
            end
         end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               queue_request(sbwq_pkg::opcode_type'($urandom_range(0, 3)),
                             $urandom_range(0, 255), $urandom_range(0, 65535),
                             pick_requester());
         end
      end
      total_requests = pending_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Checked %0d of %0d requests: %0d wakes, %0d suspends, %0d errors,",
               results_checked, total_requests, wake_count, suspend_count, error_count);
      $display("%0d full-ring rejects, %0d saturated ups, %0d mismatches.",
               ring_full_count, saturate_count, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
